// File: design/ffpa_pkg.sv
`default_nettype none
package ffpa_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BAD     = 2'd2,
    ST_OVERLAP = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WR1,
    S_WR2,
    S_OUT
  } state_t;

  localparam int IN_BITS  = 24;
  localparam int OUT_BITS = 24;

endpackage
`default_nettype wire

// File: design/first_fit_page_allocator.sv
`default_nettype none
// First-fit page allocator with coalescing. Free space is held as extents in
// one synchronous memory (one entry per page: head flag and extent length).
// Every command except a rejected one walks the memory one page per cycle;
// an add or free walks every page, while an allocate stops at the first
// fitting extent. A command rejected on its fields, or an allocate above the
// free total, answers without a walk. The single read port of the extent
// memory sets this pace. After reset a clearing pass over every page empties
// the memory; no word is accepted until it ends. One result word comes out
// per input word; a finished result waits in the output register while the
// next input word is taken.
module first_fit_page_allocator #(
  parameter int NUM_PAGES = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // [1:0] command, [11:2] base_page, [22:12] page_count, [23] zero
  input  wire logic [ffpa_pkg::IN_BITS-1:0] s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // [1:0] status, [11:2] alloc_page, [22:12] free_total, [23] zero
  output logic [ffpa_pkg::OUT_BITS-1:0]     m_tdata
);
  import ffpa_pkg::*;

  localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam int SW = ((CW > 11) ? CW : 11) + 2;
  localparam logic [SW-1:0] NP = SW'(NUM_PAGES);
  localparam logic [AW:0]   LAST = (AW + 1)'(NUM_PAGES - 1);

  // extent memory: {head, length}
  logic [CW:0] mem [NUM_PAGES];
  logic [CW:0] rdata;
  logic        wen;
  logic [AW-1:0] waddr;
  logic [CW:0] wdata;
  logic [AW:0] scan_addr, scan_addr_next;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[scan_addr[AW-1:0]];
  end

  state_t state, state_next;
  cmd_t        cmd;
  logic [SW-1:0] base, count;
  logic [CW-1:0] pool_free, pool_free_next;
  logic        chk_valid;
  logic [AW:0] chk_addr;
  logic        ovl, prev_valid, nxt_valid, found;
  logic [SW-1:0] prev_p, prev_len, nxt_len, fp, flen;
  status_t     res_status, res_status_next;
  logic [SW-1:0] res_page, res_page_next;
  logic        out_load;

  logic [SW-1:0] end_p, p_ext, len_ext;
  logic          rhead;
  assign end_p   = base + count;
  assign p_ext   = SW'(chk_addr);
  assign len_ext = SW'(rdata[CW-1:0]);
  assign rhead   = rdata[CW] && chk_valid;

  logic [SW-1:0] in_base, in_count, in_end;
  cmd_t          in_cmd;
  assign in_cmd   = cmd_t'(s_tdata[1:0]);
  assign in_base  = SW'(s_tdata[11:2]);
  assign in_count = SW'(s_tdata[22:12]);
  assign in_end   = in_base + in_count;

  logic merge_lo;
  logic [SW-1:0] new_base, new_len;
  assign merge_lo = prev_valid && (prev_p + prev_len == base);
  assign new_base = merge_lo ? prev_p : base;
  assign new_len  = (merge_lo ? prev_len : '0) + count + (nxt_valid ? nxt_len : '0);

  logic scan_last;
  assign scan_last = chk_valid && (chk_addr == LAST);

  // next state, memory write port, result
  always_comb begin
    state_next      = state;
    scan_addr_next  = scan_addr;
    pool_free_next  = pool_free;
    res_status_next = res_status;
    res_page_next   = res_page;
    wen   = 1'b0;
    waddr = '0;
    wdata = '0;
    s_tready = 1'b0;
    out_load = 1'b0;
    case (state)
      S_CLEAR: begin
        wen   = 1'b1;
        waddr = scan_addr[AW-1:0];
        scan_addr_next = scan_addr + 1'b1;
        if (scan_addr == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        scan_addr_next = '0;
        res_page_next  = '0;
        res_status_next = ST_OK;
        if (s_tvalid) begin
          if (in_cmd == CMD_NONE || in_count == '0) begin
            res_status_next = ST_BAD;
            state_next = S_OUT;
          end else if (in_cmd == CMD_ALLOC) begin
            if (in_count > SW'(pool_free)) begin
              res_status_next = ST_NOFIT;
              state_next = S_OUT;
            end else begin
              state_next = S_SCAN;
            end
          end else if (in_end > NP) begin
            res_status_next = ST_BAD;
            state_next = S_OUT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_addr <= LAST) begin
          scan_addr_next = scan_addr + 1'b1;
        end
        if (cmd == CMD_ALLOC) begin
          if (rhead && len_ext >= count) begin
            state_next = S_WR1;
          end else if (scan_last) begin
            res_status_next = ST_NOFIT;
            state_next = S_OUT;
          end
        end else if (scan_last) begin
          if (ovl || (rhead && p_ext < end_p && base < p_ext + len_ext)) begin
            res_status_next = ST_OVERLAP;
            state_next = S_OUT;
          end else begin
            state_next = S_WR1;
          end
        end
      end
      S_WR1: begin
        wen = 1'b1;
        if (cmd == CMD_ALLOC) begin
          waddr = fp[AW-1:0];
          pool_free_next = pool_free - count[CW-1:0];
          res_page_next = fp;
          state_next = (flen > count) ? S_WR2 : S_OUT;
        end else if (cmd == CMD_ADD) begin
          waddr = base[AW-1:0];
          wdata = {1'b1, count[CW-1:0]};
          pool_free_next = pool_free + count[CW-1:0];
          state_next = S_OUT;
        end else begin
          waddr = new_base[AW-1:0];
          wdata = {1'b1, new_len[CW-1:0]};
          pool_free_next = pool_free + count[CW-1:0];
          state_next = nxt_valid ? S_WR2 : S_OUT;
        end
      end
      S_WR2: begin
        wen = 1'b1;
        if (cmd == CMD_ALLOC) begin
          waddr = end_p[AW-1:0] + fp[AW-1:0] - base[AW-1:0];
          wdata = {1'b1, CW'(flen - count)};
        end else begin
          waddr = end_p[AW-1:0];
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      scan_addr  <= '0;
      pool_free  <= '0;
      chk_valid  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      scan_addr  <= scan_addr_next;
      pool_free  <= pool_free_next;
      // read data arrives the cycle after its address, so the valid flag is registered to match
      chk_valid  <= (state == S_SCAN) && (state_next == S_SCAN) && (scan_addr <= LAST);
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_addr   <= scan_addr;
    res_status <= res_status_next;
    res_page   <= res_page_next;
    if (state == S_IDLE && s_tvalid) begin
      cmd   <= in_cmd;
      // alloc tail lands at fp + count; keep base zero for that sum
      base  <= (in_cmd == CMD_ALLOC) ? '0 : in_base;
      count <= in_count;
      ovl        <= 1'b0;
      prev_valid <= 1'b0;
      nxt_valid  <= 1'b0;
      found      <= 1'b0;
    end else if (state == S_SCAN && rhead) begin
      if (cmd == CMD_ALLOC) begin
        if (len_ext >= count && !found) begin
          found <= 1'b1;
          fp    <= p_ext;
          flen  <= len_ext;
        end
      end else begin
        if (p_ext < end_p && base < p_ext + len_ext) begin
          ovl <= 1'b1;
        end
        if (p_ext < base) begin
          prev_valid <= 1'b1;
          prev_p     <= p_ext;
          prev_len   <= len_ext;
        end
        if (p_ext == end_p) begin
          nxt_valid <= 1'b1;
          nxt_len   <= len_ext;
        end
      end
    end
    if (out_load) begin
      m_tdata <= {1'b0, 11'(pool_free), res_page[9:0], res_status};
    end
  end

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    SW'(pool_free) <= NP) else $error("free total above pool size");
  a_page_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != ST_OK) |-> m_tdata[11:2] == 10'd0)
    else $error("page reported on failed command");
  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready) else $error("input taken during clear");
`endif

endmodule
`default_nettype wire

// File: test/testbench.sv
`default_nettype none

// Expected-result store for the allocator: one entry per accepted command word.
class page_scoreboard;
  logic [1:0]  want_status[$];
  logic [9:0]  want_page[$];
  logic [10:0] want_total[$];
  int          errors;
  int          checked;

  function void note_command(logic [1:0] st, logic [9:0] pg, logic [10:0] tot);
    want_status.push_back(st);
    want_page.push_back(pg);
    want_total.push_back(tot);
  endfunction

  function void check_result(logic [23:0] word);
    logic [1:0]  st;
    logic [9:0]  pg;
    logic [10:0] tot;
    if (want_status.size() == 0) begin
      $error("result word %h with nothing expected", word);
      errors++;
      return;
    end
    st  = want_status.pop_front();
    pg  = want_page.pop_front();
    tot = want_total.pop_front();
    checked++;
    if (word[1:0] !== st) begin
      $error("status expected %0d actual %0d", st, word[1:0]);
      errors++;
    end
    if (word[11:2] !== pg) begin
      $error("alloc_page expected %0d actual %0d", pg, word[11:2]);
      errors++;
    end
    if (word[22:12] !== tot) begin
      $error("free_total expected %0d actual %0d", tot, word[22:12]);
      errors++;
    end
    if (word[23] !== 1'b0) begin
      $error("pad bit expected 0 actual %b", word[23]);
      errors++;
    end
  endfunction

  function int pending();
    return want_status.size();
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffpa_pkg::*;

  localparam int PAGES = 1024;
  localparam longint CYCLE_LIMIT = 64'd20_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  first_fit_page_allocator #(.NUM_PAGES(PAGES)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: a free-extent map indexed by page.
  bit          is_head[PAGES];
  int unsigned span[PAGES];
  int unsigned model_free;

  page_scoreboard board = new();
  longint      cycles;
  int          n_alloc_ok, n_overlap, n_nofit, n_merge_cases;

  // Apply one command to the predicted free map and return the result fields.
  task automatic model_command(input cmd_t cmd, input int unsigned base,
                               input int unsigned count, output logic [1:0] st,
                               output logic [9:0] pg);
    int unsigned fin, len, p, b;
    bit hit;
    st = ST_OK;
    pg = '0;
    fin = base + count;
    if (cmd == CMD_NONE || count == 0) begin
      st = ST_BAD;
    end else if (cmd == CMD_ALLOC) begin
      st = ST_NOFIT;
      if (count <= model_free) begin
        for (p = 0; p < PAGES; p++) begin
          if (is_head[p] && span[p] >= count) begin
            len = span[p];
            is_head[p] = 0;
            if (len > count) begin
              is_head[p + count] = 1;
              span[p + count] = len - count;
            end
            model_free -= count;
            pg = p[9:0];
            st = ST_OK;
            break;
          end
        end
      end
    end else if (fin > PAGES) begin
      st = ST_BAD;
    end else begin
      hit = 0;
      for (p = 0; p < PAGES; p++)
        if (is_head[p] && p < fin && base < p + span[p]) hit = 1;
      if (hit) begin
        st = ST_OVERLAP;
      end else begin
        is_head[base] = 1;
        span[base] = count;
        model_free += count;
        if (cmd == CMD_FREE) begin
          b = base;
          // join the nearest lower extent when it ends at the base
          for (p = base; p > 0; p--) begin
            if (is_head[p - 1]) begin
              if (p - 1 + span[p - 1] == b) begin
                span[p - 1] += span[b];
                is_head[b] = 0;
                b = p - 1;
                n_merge_cases++;
              end
              break;
            end
          end
          p = b + span[b];
          if (p < PAGES && is_head[p]) begin
            span[b] += span[p];
            is_head[p] = 0;
            n_merge_cases++;
          end
        end
      end
    end
    if (st == ST_OK && cmd == CMD_ALLOC) n_alloc_ok++;
    if (st == ST_OVERLAP) n_overlap++;
    if (st == ST_NOFIT) n_nofit++;
  endtask

  // Drive one command word, wait for acceptance, and log its expectation.
  // Valid stays high after acceptance; the next word may drop it for a gap, drain drops it.
  task automatic send_word(input cmd_t cmd, input int unsigned base,
                           input int unsigned count);
    int gap;
    logic [1:0] st;
    logic [9:0] pg;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, count[10:0], base[9:0], cmd};
    do @(posedge clk); while (!s_tready);
    model_command(cmd, base, count, st, pg);
    board.note_command(st, pg, model_free[10:0]);
  endtask

  // Drop the input and hold off the sender until every expected word has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Receiver: stall at random, check every accepted result word.
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      hold = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) hold = 0;
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_result(m_tdata);
    end
  end

  // Watchdog on the cycle count.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned b, c, k, pick;
    cmd_t cmd;
    for (int i = 0; i < PAGES; i++) begin
      is_head[i] = 0;
      span[i] = 0;
    end
    model_free = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pool, field extremes, every command and error case.
    send_word(CMD_ALLOC, 0, 1);        // nothing free
    send_word(CMD_NONE, 5, 3);         // unused command
    send_word(CMD_ADD, 7, 0);          // zero count
    send_word(CMD_ADD, 1023, 2);       // past the pool
    send_word(CMD_FREE, 0, 1025);      // count above pool
    send_word(CMD_ADD, 1023, 1);       // last page
    send_word(CMD_ADD, 0, 10);
    send_word(CMD_ADD, 10, 5);         // touches, stays separate
    send_word(CMD_ADD, 5, 3);          // overlaps
    send_word(CMD_ALLOC, 1023, 12);    // no single extent fits
    send_word(CMD_ALLOC, 0, 100);      // above free total
    send_word(CMD_ALLOC, 0, 4);        // tail stays free
    send_word(CMD_FREE, 0, 4);         // merges upward
    send_word(CMD_ALLOC, 0, 10);
    send_word(CMD_ALLOC, 0, 5);
    send_word(CMD_FREE, 4, 3);         // no neighbors
    send_word(CMD_FREE, 7, 3);         // joins lower
    send_word(CMD_FREE, 0, 4);         // joins upper
    send_word(CMD_FREE, 10, 1013);     // joins both sides
    send_word(CMD_ALLOC, 0, 1024);     // whole pool
    send_word(CMD_FREE, 0, 1024);
    send_word(CMD_ALLOC, 0, 0);        // zero allocate
    drain();

    // Random: mostly alloc/free churn with small sizes, some noise.
    for (k = 0; k < 1600; k++) begin
      pick = $urandom_range(0, 99);
      b = $urandom_range(0, 1023);
      if ($urandom_range(0, 19) == 0) c = $urandom_range(0, 1024);
      else c = $urandom_range(1, 40);
      if (pick < 40) cmd = CMD_ALLOC;
      else if (pick < 85) cmd = CMD_FREE;
      else if (pick < 95) cmd = CMD_ADD;
      else cmd = CMD_NONE;
      if (cmd != CMD_ALLOC && b + c > PAGES && $urandom_range(0, 3) != 0)
        c = PAGES - b;
      send_word(cmd, b, c);
      if (k == 800) drain();
    end
    drain();
    repeat (3 * PAGES) @(posedge clk);

    $display("checked %0d result words: %0d allocations, %0d no-fit, %0d overlap,",
             board.checked, n_alloc_ok, n_nofit, n_overlap);
    $display("%0d neighbor merges on free", n_merge_cases);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: first_fit_page_allocator.f
design/ffpa_pkg.sv
design/first_fit_page_allocator.sv
test/testbench.sv
